// File: sv/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// Depends on nothing; the interfaces and the top level import it.
package sha1md_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 64;

    localparam logic [WORD_W-1:0] C_IV [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] C_K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] C_K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] C_K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] C_K3 = 32'hCA62C1D6;

    localparam logic [BYTE_W-1:0] C_PAD_BYTE = 8'h80;

    localparam logic [6:0] C_LAST_ROUND = 7'd79;
    localparam logic [5:0] C_LEN_POS    = 6'd56;
    localparam logic [3:0] C_LEN_HI_IDX = 4'd14;
    localparam logic [3:0] C_LEN_LO_IDX = 4'd15;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PAD    = 8'b0000_0010,
        S_LEN_HI = 8'b0000_0100,
        S_LEN_LO = 8'b0000_1000,
        S_CSTART = 8'b0001_0000,
        S_ROUND  = 8'b0010_0000,
        S_CADD   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        AFT_DATA = 2'd0,
        AFT_PAD  = 2'd1,
        AFT_OUT  = 2'd2
    } t_after;

endpackage

// File: sv/sha1md_if.sv
// Handshake channels of the SHA-1 message digest block: message bytes in, digest words out.
// Depends on sha1md_pkg for the payload widths.
interface sha1md_msg_if import sha1md_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1md_dig_if import sha1md_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic              digest_last;

    modport source (output valid, digest_word, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// File: sv/sha1_message_digest_top.sv
// SHA-1 message digest: one message byte per input beat, five digest words per message.
// A byte beat is taken only in the idle state; the 64th byte of a block starts a compression:
// a start state, then 80 rounds of a read phase and a compute phase each, then a chaining add.
// An end beat adds up to 64 padding byte writes, two length writes and one or two compressions,
// then five output beats. Reset loads the initial chaining values and clears all counters;
// the block memory is not cleared.
module sha1_message_digest_top import sha1md_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1md_msg_if.sink   i_msg,
    sha1md_dig_if.source o_digest
);

    logic [WORD_W-1:0] r_blk [0:15];
    logic [WORD_W-1:0] r_q0, r_q1;

    t_state            r_state, n_state;
    t_after            r_after, n_after;
    logic [5:0]        r_pos, n_pos;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_chain [0:4];
    logic [WORD_W-1:0] n_chain [0:4];
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WORD_W-1:0] n_a, n_b, n_c, n_d, n_e;
    logic [WORD_W-1:0] r_x, n_x;
    logic [6:0]        r_rnd, n_rnd;
    logic              r_ph, n_ph;
    logic              r_first, n_first;
    logic [2:0]        r_k, n_k;

    logic              wr_en;
    logic [3:0]        wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [3:0]        rd_addr0, rd_addr1;

    logic [BYTE_W-1:0] put_val;
    logic [WORD_W-1:0] lane;
    logic [WORD_W-1:0] put_word;
    logic [3:0]        j, jn;
    logic [WORD_W-1:0] wx, w_exp, w_cur, f, k, t;
    logic              in_acc, out_acc;

    assign in_acc  = i_msg.valid && i_msg.ready;
    assign out_acc = o_digest.valid && o_digest.ready;

    assign i_msg.ready          = (r_state == S_IDLE);
    assign o_digest.valid       = (r_state == S_OUT);
    assign o_digest.digest_word = r_chain[r_k];
    assign o_digest.digest_last = (r_k == 3'd4);

    always_comb begin
        put_val = (r_state == S_PAD) ? (r_first ? C_PAD_BYTE : '0) : i_msg.data_byte;
        lane    = {put_val, 24'h000000} >> {r_pos[1:0], 3'b000};
        if (r_pos[1:0] == 2'd0) begin
            put_word = lane;
        end else begin
            put_word = r_word | lane;
        end
    end

    always_comb begin
        j     = r_rnd[3:0];
        jn    = j + 4'd1;
        wx    = r_x ^ r_q0 ^ r_q1;
        w_exp = {wx[30:0], wx[31]};
        w_cur = (r_rnd < 7'd16) ? r_q0 : w_exp;
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = C_K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = C_K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = C_K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = C_K3;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w_cur;
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_pos   = r_pos;
        n_len   = r_len;
        n_word  = r_word;
        n_chain = r_chain;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_e     = r_e;
        n_x     = r_x;
        n_rnd   = r_rnd;
        n_ph    = r_ph;
        n_first = r_first;
        n_k     = r_k;
        wr_en   = 1'b0;
        wr_addr = r_pos[5:2];
        wr_data = put_word;
        rd_addr0 = '0;
        rd_addr1 = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_msg.has_byte) begin
                        wr_en  = 1'b1;
                        n_word = put_word;
                        n_pos  = r_pos + 6'd1;
                        n_len  = r_len + LEN_W'(8);
                    end
                    n_first = 1'b1;
                    if (i_msg.has_byte && r_pos == 6'd63) begin
                        n_state = S_CSTART;
                        n_after = i_msg.end_of_message ? AFT_PAD : AFT_DATA;
                    end else if (i_msg.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                wr_en   = 1'b1;
                n_word  = put_word;
                n_pos   = r_pos + 6'd1;
                n_first = 1'b0;
                if (r_pos == 6'd63) begin
                    n_state = S_CSTART;
                    n_after = AFT_PAD;
                end else if (r_pos + 6'd1 == C_LEN_POS) begin
                    n_state = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                wr_en   = 1'b1;
                wr_addr = C_LEN_HI_IDX;
                wr_data = r_len[63:32];
                n_state = S_LEN_LO;
            end
            S_LEN_LO: begin
                wr_en   = 1'b1;
                wr_addr = C_LEN_LO_IDX;
                wr_data = r_len[31:0];
                n_state = S_CSTART;
                n_after = AFT_OUT;
            end
            S_CSTART: begin
                n_a      = r_chain[0];
                n_b      = r_chain[1];
                n_c      = r_chain[2];
                n_d      = r_chain[3];
                n_e      = r_chain[4];
                n_rnd    = '0;
                n_ph     = 1'b1;
                rd_addr0 = 4'd8;
                rd_addr1 = 4'd13;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                if (r_ph) begin
                    n_x      = r_q0 ^ r_q1;
                    rd_addr0 = j;
                    rd_addr1 = j + 4'd2;
                    n_ph     = 1'b0;
                end else begin
                    if (r_rnd >= 7'd16) begin
                        wr_en   = 1'b1;
                        wr_addr = j;
                        wr_data = w_exp;
                    end
                    n_e = r_d;
                    n_d = r_c;
                    n_c = {r_b[1:0], r_b[31:2]};
                    n_b = r_a;
                    n_a = t;
                    if (r_rnd == C_LAST_ROUND) begin
                        n_state = S_CADD;
                    end else begin
                        n_rnd    = r_rnd + 7'd1;
                        rd_addr0 = jn + 4'd8;
                        rd_addr1 = jn + 4'd13;
                        n_ph     = 1'b1;
                    end
                end
            end
            S_CADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                n_rnd      = '0;
                case (r_after)
                    AFT_PAD: n_state = S_PAD;
                    AFT_OUT: begin
                        n_state = S_OUT;
                        n_k     = '0;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_k == 3'd4) begin
                        n_chain = C_IV;
                        n_len   = '0;
                        n_pos   = '0;
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_blk[wr_addr] <= wr_data;
        end
        r_q0 <= r_blk[rd_addr0];
        r_q1 <= r_blk[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= AFT_DATA;
            r_pos   <= '0;
            r_len   <= '0;
            r_chain <= C_IV;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            r_rnd   <= '0;
            r_ph    <= 1'b0;
            r_first <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_chain <= n_chain;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_e     <= n_e;
            r_rnd   <= n_rnd;
            r_ph    <= n_ph;
            r_first <= n_first;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_x    <= n_x;
    end

endmodule
